/* hdl/stbs_pkg.sv */
// shared types and constants for the sorted table bound search unit
// no dependencies; imported by every module of the unit
`timescale 1ns / 1ps

package stbs_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int CNT_W           = 9;
    localparam int IDX_W           = 8;
    localparam int VAL_W           = 32;
    localparam int REQ_W           = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOWER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UPPER = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_HOLD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_we;
        logic start;
        logic step;
        logic out_load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic range_open;
    } t_dp_status;

endpackage

/* hdl/stbs_ctrl.sv */
// sequencer for the bound search: accepts beats, steps the halving loop
// depends on stbs_pkg
`timescale 1ns / 1ps

module stbs_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [stbs_pkg::REQ_W-1:0] i_req_type,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  stbs_pkg::t_dp_status      i_status,
    output stbs_pkg::t_ctrl_cmd       o_cmd
);
    import stbs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_fire;
    logic   is_query;
    logic   out_free;

    assign in_fire  = i_in_valid && (r_state == ST_IDLE);
    assign is_query = (i_req_type == REQ_LOWER) || (i_req_type == REQ_UPPER);
    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && is_query) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (i_status.range_open) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_CMP: begin
                n_state = ST_READ;
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_we = in_fire && (i_req_type == REQ_LOAD);
                o_cmd.start   = in_fire && is_query;
            end
            ST_READ: begin
            end
            ST_CMP: begin
                o_cmd.step = 1'b1;
            end
            ST_HOLD: begin
                o_cmd.out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/stbs_dpath.sv */
// datapath: entry table, count register, search bounds and result register
// depends on stbs_pkg; driven by stbs_ctrl commands
`timescale 1ns / 1ps

module stbs_dpath #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [stbs_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic [stbs_pkg::REQ_W-1:0] i_req_type,
    input  logic [stbs_pkg::IDX_W-1:0] i_entry_index,
    input  logic signed [stbs_pkg::VAL_W-1:0] i_item_value,
    input  stbs_pkg::t_ctrl_cmd        i_cmd,
    output stbs_pkg::t_dp_status       o_status,
    output logic [stbs_pkg::CNT_W-1:0] o_bound_index,
    output logic                       o_was_upper
);
    import stbs_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic signed [VAL_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;
    logic signed [VAL_W-1:0] r_target;
    logic                    r_upper;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_lo;
    logic [CNT_W-1:0]        r_hi;
    logic [CNT_W-1:0]        r_bound;
    logic                    r_was_upper;
    logic [CNT_W-1:0]        mid;
    logic [CNT_W-1:0]        sat_count;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic                    wr_in_range;
    logic                    go_right;

    // count clipped to the table size
    assign sat_count = (32'(r_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : r_count;

    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign rd_addr = AW'(mid);
    assign wr_addr = AW'(i_entry_index);
    assign wr_in_range = 32'(i_entry_index) < 32'(TABLE_DEPTH);

    // lower: move right past entries below target; upper: also past equal ones
    assign go_right = r_upper ? (r_rd_data <= r_target) : (r_rd_data < r_target);

    assign o_status.range_open = r_lo < r_hi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && wr_in_range) begin
            r_mem[wr_addr] <= i_item_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_target <= i_item_value;
            r_upper  <= (i_req_type == REQ_UPPER);
            r_lo     <= '0;
            r_hi     <= sat_count;
        end else if (i_cmd.step) begin
            if (go_right) begin
                r_lo <= mid + CNT_W'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.out_load) begin
            r_bound     <= r_lo;
            r_was_upper <= r_upper;
        end
    end

    assign o_bound_index = r_bound;
    assign o_was_upper   = r_was_upper;

endmodule

/* hdl/sorted_table_bound_search_unit.sv */
// a query runs s steps of the halving loop (at most ceil(log2(count+1)), so
// at most 9 for a 256-entry table), each one read, then one compare, on the
// single table read port; a new request is not taken until the result is in
// the output register; loads are taken every cycle while the sequencer is idle
// reset: synchronous active-low, clears table_count, the sequencer and out valid;
// the table contents are not cleared
`timescale 1ns / 1ps

module sorted_table_bound_search_unit #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: table_count
    input  logic                       i_cfg_we,
    input  logic [stbs_pkg::CNT_W-1:0] i_cfg_wdata,
    // request beats
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [stbs_pkg::REQ_W-1:0] i_req_type,
    input  logic [stbs_pkg::IDX_W-1:0] i_entry_index,
    input  logic signed [stbs_pkg::VAL_W-1:0] i_item_value,
    // result beats
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [stbs_pkg::CNT_W-1:0] o_bound_index,
    output logic                       o_was_upper
);
    import stbs_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // sequencer: idle takes beats (loads write straight into the table),
    // a query then alternates read and compare until the range is empty,
    // and the answer waits in hold until the result register is free
    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // table memory, bounds [lo, hi) and the output register
    stbs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_item_value  (i_item_value),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_bound_index (o_bound_index),
        .o_was_upper   (o_was_upper)
    );

endmodule

/* hdl/stbs_checker.sv */
// port-level checks for the bound search unit, bound to the top level
// depends on stbs_pkg
`timescale 1ns / 1ps

module stbs_checker #(
    parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [stbs_pkg::REQ_W-1:0] i_req_type,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [stbs_pkg::CNT_W-1:0] o_bound_index,
    input logic                       o_was_upper
);
    import stbs_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_bound_index) && $stable(o_was_upper)))
        else $error("result beat changed while stalled");

    // answer never lies beyond the table
    a_bound_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_bound_index) <= 32'(TABLE_DEPTH)))
        else $error("bound index beyond table depth");

    // accepting a query takes in-ready low
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready &&
            ((i_req_type == REQ_LOWER) || (i_req_type == REQ_UPPER))) |=> !o_in_ready)
        else $error("request accepted during a search");

    // reset empties the result register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sorted_table_bound_search_unit stbs_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_stbs_checker (.*);
